// ===== rtl/i2cbm_pkg.sv =====
// i2cbm_pkg: shared types for the byte-level I2C master.
// Command codes, input transaction and result transaction structs.
// No dependencies.
package i2cbm_pkg;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } cmd_t;

    localparam logic [9:0] HALF_PERIOD_RST = 10'd5;
    localparam logic [3:0] BITS_PER_BYTE   = 4'd8;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] wdata;
        logic       send_ack;
        logic       sda_in;
    } in_t;

    typedef struct packed {
        logic       scl;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rdata;
        logic       nack;
    } res_t;

endpackage

// ===== rtl/i2cbm_if.sv =====
// i2cbm_in_if / i2cbm_out_if: valid/ready channels of the I2C master.
// Payload fields follow i2cbm_pkg; no other dependencies.
interface i2cbm_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [7:0] wdata;
    logic       send_ack;
    logic       sda_in;

    modport source (output valid, output func, output wdata, output send_ack,
                    output sda_in, input ready);
    modport sink   (input valid, input func, input wdata, input send_ack,
                    input sda_in, output ready);
endinterface

interface i2cbm_out_if;
    logic       valid;
    logic       ready;
    logic       scl;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rdata;
    logic       nack;

    modport source (output valid, output scl, output sda_release, output busy_res,
                    output done_res, output rdata, output nack, input ready);
    modport sink   (input valid, input scl, input sda_release, input busy_res,
                    input done_res, input rdata, input nack, output ready);
endinterface

// ===== rtl/i2cbm_seq.sv =====
// i2cbm_seq: bus phase sequencer, one tick per accepted transaction.
// Holds command state and the half_period register; uses i2cbm_pkg.
module i2cbm_seq
    import i2cbm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       acc,
    input  in_t        item,
    input  logic       cfg_we,
    input  logic [9:0] cfg_wdata,
    output res_t       res
);

    cmd_t       command_reg, command_next;
    logic [2:0] phase_reg, phase_next;
    logic [3:0] bit_count_reg, bit_count_next;
    logic [9:0] tick_count_reg, tick_count_next;
    logic [7:0] shift_reg, shift_next;
    logic       ack_choice_reg, ack_choice_next;
    logic       line_scl_reg, line_scl_next;
    logic       line_sda_reg, line_sda_next;
    logic       nack_flag_reg, nack_flag_next;
    logic [7:0] rx_byte_reg, rx_byte_next;
    logic [9:0] half_period_reg;

    logic [9:0] hp;
    logic [9:0] tick_inc;
    logic       c, d, finish;

    always_comb
    begin
        hp = (half_period_reg == 10'd0) ? 10'd1 : half_period_reg;

        command_next    = command_reg;
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        tick_count_next = tick_count_reg;
        shift_next      = shift_reg;
        ack_choice_next = ack_choice_reg;
        nack_flag_next  = nack_flag_reg;
        rx_byte_next    = rx_byte_reg;
        finish          = 1'b0;
        tick_inc        = 10'd0;

        if (command_reg == CMD_NONE && item.func inside {[CMD_START:CMD_READ]})
        begin
            command_next    = cmd_t'(item.func);
            phase_next      = 3'd0;
            bit_count_next  = 4'd0;
            tick_count_next = 10'd0;
            if (item.func == CMD_WRITE)
            begin
                shift_next = item.wdata;
            end
            if (item.func == CMD_READ)
            begin
                shift_next      = 8'd0;
                ack_choice_next = item.send_ack;
            end
        end

        c = line_scl_reg;
        d = line_sda_reg;

        // bus levels of the current phase
        case (command_next)
            CMD_START:
            begin
                c = (phase_next <= 3'd1);
                d = (phase_next == 3'd0);
            end
            CMD_STOP:
            begin
                c = (phase_next >= 3'd2);
                d = (phase_next == 3'd0) ? line_sda_reg : (phase_next >= 3'd3);
            end
            CMD_WRITE:
            begin
                case (phase_next)
                    3'd0:    begin c = 1'b0; d = shift_next[7]; end
                    3'd1:    begin c = 1'b1; d = shift_next[7]; end
                    3'd2:    begin c = 1'b0; d = line_sda_reg; end
                    3'd3:    begin c = 1'b0; d = 1'b1; end
                    default: begin c = 1'b1; d = 1'b1; end
                endcase
            end
            CMD_READ:
            begin
                if (phase_next == 3'd0)
                begin
                    c = 1'b1; d = 1'b1;
                end
                else if (phase_next == 3'd1)
                begin
                    c = 1'b0; d = 1'b1;
                end
                else if (ack_choice_next)
                begin
                    c = (phase_next == 3'd3); d = 1'b0;
                end
                else
                begin
                    c = (phase_next == 3'd4); d = 1'b1;
                end
            end
            default: ;
        endcase

        line_scl_next = c;
        line_sda_next = d;

        if (command_next != CMD_NONE)
        begin
            tick_inc        = tick_count_next + 10'd1;
            tick_count_next = tick_inc;
            if (tick_inc >= hp || tick_inc == 10'd0)
            begin
                tick_count_next = 10'd0;
                case (command_next)
                    CMD_START:
                    begin
                        if (phase_next >= 3'd2) finish = 1'b1;
                        else phase_next = phase_next + 3'd1;
                    end
                    CMD_STOP:
                    begin
                        if (phase_next >= 3'd3) finish = 1'b1;
                        else phase_next = phase_next + 3'd1;
                    end
                    CMD_WRITE:
                    begin
                        if (phase_next == 3'd0)
                        begin
                            phase_next = 3'd1;
                        end
                        else if (phase_next == 3'd1)
                        begin
                            shift_next     = {shift_next[6:0], 1'b0};
                            bit_count_next = bit_count_next + 4'd1;
                            phase_next     = (bit_count_next >= BITS_PER_BYTE) ? 3'd2 : 3'd0;
                        end
                        else if (phase_next < 3'd4)
                        begin
                            phase_next = phase_next + 3'd1;
                        end
                        else
                        begin
                            nack_flag_next = item.sda_in;
                            line_scl_next  = 1'b0;
                            line_sda_next  = 1'b1;
                            finish         = 1'b1;
                        end
                    end
                    CMD_READ:
                    begin
                        if (phase_next == 3'd0)
                        begin
                            shift_next = {shift_next[6:0], item.sda_in};
                            phase_next = 3'd1;
                        end
                        else if (phase_next == 3'd1)
                        begin
                            bit_count_next = bit_count_next + 4'd1;
                            phase_next     = (bit_count_next >= BITS_PER_BYTE) ? 3'd2 : 3'd0;
                        end
                        else if (phase_next >= (ack_choice_next ? 3'd4 : 3'd5))
                        begin
                            rx_byte_next = shift_next;
                            finish       = 1'b1;
                        end
                        else
                        begin
                            phase_next = phase_next + 3'd1;
                        end
                    end
                    default: ;
                endcase
                if (finish)
                begin
                    command_next   = CMD_NONE;
                    phase_next     = 3'd0;
                    bit_count_next = 4'd0;
                end
            end
        end

        res.scl         = c;
        res.sda_release = d;
        res.busy_res    = (command_next != CMD_NONE) || finish;
        res.done_res    = finish;
        res.rdata       = rx_byte_next;
        res.nack        = nack_flag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            command_reg     <= CMD_NONE;
            phase_reg       <= 3'd0;
            bit_count_reg   <= 4'd0;
            tick_count_reg  <= 10'd0;
            shift_reg       <= 8'd0;
            ack_choice_reg  <= 1'b0;
            line_scl_reg    <= 1'b1;
            line_sda_reg    <= 1'b1;
            nack_flag_reg   <= 1'b0;
            rx_byte_reg     <= 8'd0;
            half_period_reg <= HALF_PERIOD_RST;
        end
        else
        begin
            if (cfg_we)
            begin
                half_period_reg <= cfg_wdata;
            end
            if (acc)
            begin
                command_reg    <= command_next;
                phase_reg      <= phase_next;
                bit_count_reg  <= bit_count_next;
                tick_count_reg <= tick_count_next;
                shift_reg      <= shift_next;
                ack_choice_reg <= ack_choice_next;
                line_scl_reg   <= line_scl_next;
                line_sda_reg   <= line_sda_next;
                nack_flag_reg  <= nack_flag_next;
                rx_byte_reg    <= rx_byte_next;
            end
        end
    end

endmodule

// ===== rtl/i2cbm_obuf.sv =====
// i2cbm_obuf: result register plus skid entry in front of the output channel.
// Uses i2cbm_pkg and i2cbm_out_if.
module i2cbm_obuf
    import i2cbm_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  res_t                push_data,
    output logic                push_ready,
    i2cbm_out_if.source         res_port
);

    logic main_valid_reg, main_valid_next;
    logic skid_valid_reg, skid_valid_next;
    res_t main_reg, main_next;
    res_t skid_reg, skid_next;
    logic take;

    assign push_ready = !skid_valid_reg;
    assign take       = main_valid_reg && res_port.ready;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_next       = push_data;
                skid_valid_next = push;
            end
            else
            begin
                main_next       = push_data;
                main_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = push_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign res_port.valid       = main_valid_reg;
    assign res_port.scl         = main_reg.scl;
    assign res_port.sda_release = main_reg.sda_release;
    assign res_port.busy_res    = main_reg.busy_res;
    assign res_port.done_res    = main_reg.done_res;
    assign res_port.rdata       = main_reg.rdata;
    assign res_port.nack        = main_reg.nack;

endmodule

// ===== rtl/i2c_byte_master_unit.sv =====
// i2c_byte_master_unit: byte-level I2C master, one bus tick per transaction.
// Throughput: one tick per cycle while the result buffer has room; a two-entry result buffer absorbs stalls.
// Reset: idle, both lines released high, flags zero, half_period 5.
// Depends on i2cbm_pkg, i2cbm_if, i2cbm_seq, i2cbm_obuf.
module i2c_byte_master_unit
    import i2cbm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    i2cbm_in_if.sink      cmd,
    i2cbm_out_if.source   res,
    input  logic          cfg_we,
    input  logic [9:0]    cfg_wdata
);

    in_t  item;
    res_t tick_res;
    logic acc;
    logic buf_ready;

    assign cmd.ready     = buf_ready;
    assign acc           = cmd.valid && buf_ready;
    assign item.func     = cmd.func;
    assign item.wdata    = cmd.wdata;
    assign item.send_ack = cmd.send_ack;
    assign item.sda_in   = cmd.sda_in;

    i2cbm_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .acc       (acc),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .res       (tick_res)
    );

    i2cbm_obuf u_obuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (acc),
        .push_data  (tick_res),
        .push_ready (buf_ready),
        .res_port   (res)
    );

endmodule

// ===== tb/sv/i2cbm_bus_checker.sv =====
// i2cbm_bus_checker: watches the tick and result channels of the I2C byte master,
// predicts every bus tick and compares each result transaction field by field.
// Depends on i2cbm_pkg and the i2cbm_in_if / i2cbm_out_if interfaces.
`timescale 1ns / 1ps
module i2cbm_bus_checker
    import i2cbm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    i2cbm_in_if        cmd,
    i2cbm_out_if       res,
    input  logic       cfg_we,
    input  logic [9:0] cfg_wdata,
    output int         mismatches,
    output int         outstanding
);

    cmd_t       cur_cmd;
    logic [4:0] ph;
    logic [3:0] nbits;
    logic [9:0] ticks;
    logic [7:0] shreg;
    logic       ack_sel;
    logic       line_scl;
    logic       line_sda;
    logic       nack_q;
    logic [7:0] rx_q;
    logic [9:0] hp_reg;
    res_t       line_q[$];

    function automatic res_t bus_tick(in_t t);
        res_t       r;
        logic       s;
        logic       a;
        logic       fin;
        logic [9:0] hp;
        hp  = (hp_reg == '0) ? 10'd1 : hp_reg;
        r   = '0;
        s   = line_scl;
        a   = line_sda;
        fin = 1'b0;
        if (cur_cmd == CMD_NONE && t.func >= CMD_START && t.func <= CMD_READ)
        begin
            cur_cmd = cmd_t'(t.func);
            ph      = '0;
            nbits   = '0;
            ticks   = '0;
            if (cur_cmd == CMD_WRITE)
                shreg = t.wdata;
            if (cur_cmd == CMD_READ)
            begin
                shreg   = '0;
                ack_sel = t.send_ack;
            end
        end
        if (cur_cmd != CMD_NONE)
        begin
            r.busy_res = 1'b1;
            case (cur_cmd)
                CMD_START:
                begin
                    s = (ph < 5'd2);
                    a = (ph == 5'd0);
                end
                CMD_STOP:
                begin
                    s = (ph >= 5'd2);
                    a = (ph == 5'd0) ? line_sda : (ph == 5'd3);
                end
                CMD_WRITE:
                begin
                    s = (ph == 5'd1 || ph >= 5'd4);
                    a = (ph <= 5'd1) ? shreg[7] : (ph == 5'd2) ? line_sda : 1'b1;
                end
                default:
                begin
                    if (ph == 5'd0)
                    begin
                        s = 1'b1;
                        a = 1'b1;
                    end
                    else if (ph == 5'd1)
                    begin
                        s = 1'b0;
                        a = 1'b1;
                    end
                    else if (ack_sel)
                    begin
                        s = (ph == 5'd3);
                        a = 1'b0;
                    end
                    else
                    begin
                        s = (ph == 5'd4);
                        a = 1'b1;
                    end
                end
            endcase
            line_scl = s;
            line_sda = a;
            ticks    = ticks + 10'd1;
            if (ticks >= hp || ticks == '0)
            begin
                ticks = '0;
                case (cur_cmd)
                    CMD_START:
                        if (ph >= 5'd2) fin = 1'b1; else ph++;
                    CMD_STOP:
                        if (ph >= 5'd3) fin = 1'b1; else ph++;
                    CMD_WRITE:
                    begin
                        if (ph == 5'd0)
                            ph = 5'd1;
                        else if (ph == 5'd1)
                        begin
                            shreg = shreg << 1;
                            nbits++;
                            ph = (nbits >= BITS_PER_BYTE) ? 5'd2 : 5'd0;
                        end
                        else if (ph < 5'd4)
                            ph++;
                        else
                        begin
                            // ack sampled on the last tick of the acknowledge clock
                            nack_q   = t.sda_in;
                            line_scl = 1'b0;
                            line_sda = 1'b1;
                            fin      = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (ph == 5'd0)
                        begin
                            shreg = {shreg[6:0], t.sda_in};
                            ph    = 5'd1;
                        end
                        else if (ph == 5'd1)
                        begin
                            nbits++;
                            ph = (nbits >= BITS_PER_BYTE) ? 5'd2 : 5'd0;
                        end
                        else if (ph >= (ack_sel ? 5'd4 : 5'd5))
                        begin
                            rx_q = shreg;
                            fin  = 1'b1;
                        end
                        else
                            ph++;
                    end
                endcase
                if (fin)
                begin
                    cur_cmd    = CMD_NONE;
                    ph         = '0;
                    nbits      = '0;
                    r.done_res = 1'b1;
                end
            end
        end
        r.scl         = s;
        r.sda_release = a;
        r.rdata       = rx_q;
        r.nack        = nack_q;
        return r;
    endfunction

    function automatic int field_err(string name, logic [7:0] want, logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        res_t want;
        in_t  item;
        int   nbad;
        if (!rst_n)
        begin
            cur_cmd     = CMD_NONE;
            ph          = '0;
            nbits       = '0;
            ticks       = '0;
            shreg       = '0;
            ack_sel     = 1'b0;
            line_scl    = 1'b1;
            line_sda    = 1'b1;
            nack_q      = 1'b0;
            rx_q        = '0;
            hp_reg      = HALF_PERIOD_RST;
            mismatches  = 0;
            outstanding = 0;
            line_q.delete();
        end
        else
        begin
            if (res.valid && res.ready)
            begin
                if (line_q.size() == 0)
                begin
                    $error("result transaction with nothing expected");
                    mismatches++;
                end
                else
                begin
                    want = line_q.pop_front();
                    nbad = field_err("scl", 8'(want.scl), 8'(res.scl))
                         + field_err("sda_release", 8'(want.sda_release),
                                     8'(res.sda_release))
                         + field_err("busy_res", 8'(want.busy_res), 8'(res.busy_res))
                         + field_err("done_res", 8'(want.done_res), 8'(res.done_res))
                         + field_err("rdata", want.rdata, res.rdata)
                         + field_err("nack", 8'(want.nack), 8'(res.nack));
                    if (nbad != 0)
                        mismatches++;
                end
            end
            if (cmd.valid && cmd.ready)
            begin
                item.func     = cmd.func;
                item.wdata    = cmd.wdata;
                item.send_ack = cmd.send_ack;
                item.sda_in   = cmd.sda_in;
                line_q.push_back(bus_tick(item));
            end
            if (cfg_we)
                hp_reg = cfg_wdata;
            outstanding = line_q.size();
        end
    end

endmodule

// ===== tb/sv/i2c_byte_master_unit_tb.sv =====
// i2c_byte_master_unit_tb: drives bus ticks and half-period settings into the
// I2C byte master with random idle and stall, and gives the verdict.
// Depends on i2cbm_pkg, the i2cbm interfaces, i2cbm_bus_checker and the RTL.
`timescale 1ns / 1ps
module i2c_byte_master_unit_tb;
    import i2cbm_pkg::*;

    localparam int         CYCLE_LIMIT    = 2000000;
    localparam int         SDA_LOW        = 0;
    localparam int         SDA_HIGH       = 1;
    localparam int         SDA_RAND       = 2;
    localparam logic [2:0] FUNC_BAD_FIRST = 3'd5;
    localparam logic [2:0] FUNC_BAD_LAST  = 3'd7;
    localparam int         TICKS_PER_HP   = 30;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [9:0] cfg_wdata;
    int         mismatches;
    int         outstanding;
    int         cycles;
    int         ticks_sent;
    int         stall_left;
    logic [9:0] hp_now;
    bit         in_gaps;
    bit         out_gaps;

    i2cbm_in_if  cmd_if ();
    i2cbm_out_if res_if ();

    i2c_byte_master_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_if),
        .res       (res_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    i2cbm_bus_checker i_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_if),
        .res         (res_if),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("i2c_byte_master_unit_tb NOT OK");
            $finish;
        end
    end

    function automatic int pick_gap(int pct_zero);
        int r;
        r = $urandom_range(0, 99);
        if (r < pct_zero)
            return 0;
        if (r < 97)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(negedge clk)
    begin
        if ($urandom_range(0, 299) == 0)
            out_gaps = !out_gaps;
        if (stall_left > 0)
        begin
            stall_left--;
            res_if.ready <= 1'b0;
        end
        else
        begin
            res_if.ready <= 1'b1;
            if (out_gaps)
                stall_left = pick_gap(75);
        end
    end

    task automatic send_tick(logic [2:0] f, logic [7:0] b, logic ack, logic sda);
        int gap;
        gap = in_gaps ? pick_gap(60) : 0;
        if (gap > 0)
        begin
            cmd_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_if.valid    <= 1'b1;
        cmd_if.func     <= f;
        cmd_if.wdata    <= b;
        cmd_if.send_ack <= ack;
        cmd_if.sda_in   <= sda;
        ticks_sent++;
        do @(posedge clk); while (!cmd_if.ready);
        @(negedge clk);
    endtask

    function automatic logic sda_bit(int mode);
        if (mode == SDA_RAND)
            return 1'($urandom);
        return (mode == SDA_HIGH);
    endfunction

    // command tick, then fillers up to the expected end plus slack
    task automatic run_cmd(cmd_t c, logic [7:0] b, logic ack, int sda_mode, int slack,
                           bit noisy);
        int         hpe;
        int         n;
        logic [2:0] f;
        hpe = (hp_now == '0) ? 1 : int'(hp_now);
        case (c)
            CMD_START: n = 3 * hpe;
            CMD_STOP:  n = 4 * hpe;
            CMD_WRITE: n = 19 * hpe;
            default:   n = (ack ? 19 : 20) * hpe;
        endcase
        n = n - 1 + slack;
        send_tick(c, b, ack, sda_bit(sda_mode));
        for (int i = 0; i < n; i++)
        begin
            f = (noisy && $urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : CMD_NONE;
            send_tick(f, 8'($urandom), 1'($urandom), sda_bit(sda_mode));
        end
    endtask

    function automatic int pick_slack();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(0, 2);
        return -$urandom_range(1, 3);
    endfunction

    task automatic bus_frame();
        int n;
        in_gaps = ($urandom_range(0, 3) != 0);
        run_cmd(CMD_START, 8'($urandom), 1'b0, SDA_RAND, pick_slack(), 1'b1);
        run_cmd(CMD_WRITE, 8'($urandom), 1'b0, $urandom_range(0, 2), pick_slack(), 1'b1);
        n = $urandom_range(0, 3);
        repeat (n)
        begin
            if ($urandom_range(0, 1))
                run_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), $urandom_range(0, 2),
                        pick_slack(), 1'b1);
            else
                run_cmd(CMD_READ, 8'($urandom), 1'($urandom), $urandom_range(0, 2),
                        pick_slack(), 1'b1);
        end
        run_cmd(CMD_STOP, 8'($urandom), 1'b0, SDA_RAND, pick_slack(), 1'b1);
    endtask

    task automatic settle(int n_idle);
        repeat (n_idle) send_tick(CMD_NONE, 8'($urandom), 1'($urandom), 1'($urandom));
        cmd_if.valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_half_period(logic [9:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        hp_now     = v;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        int hp_plan[7];
        int mark;
        int hpe;
        clk             = 1'b0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        cmd_if.valid    = 1'b0;
        cmd_if.func     = CMD_NONE;
        cmd_if.wdata    = '0;
        cmd_if.send_ack = 1'b0;
        cmd_if.sda_in   = 1'b0;
        res_if.ready    = 1'b0;
        cycles          = 0;
        ticks_sent      = 0;
        stall_left      = 0;
        hp_now          = HALF_PERIOD_RST;
        in_gaps         = 1'b1;
        out_gaps        = 1'b1;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // idle and unknown commands, then one start at the reset half period
        send_tick(CMD_NONE, 8'h00, 1'b0, 1'b0);
        for (int f = FUNC_BAD_FIRST; f <= FUNC_BAD_LAST; f++)
            send_tick(3'(f), 8'hFF, 1'b1, 1'b1);
        run_cmd(CMD_START, 8'h00, 1'b0, SDA_HIGH, 0, 1'b0);
        settle(0);

        set_half_period(10'd1);
        run_cmd(CMD_START, 8'h00, 1'b0, SDA_HIGH, 0, 1'b0);
        run_cmd(CMD_WRITE, 8'hFF, 1'b0, SDA_LOW, 0, 1'b0);
        run_cmd(CMD_WRITE, 8'h00, 1'b1, SDA_HIGH, 0, 1'b0);
        run_cmd(CMD_WRITE, 8'hA5, 1'b0, SDA_RAND, 0, 1'b1);
        run_cmd(CMD_READ, 8'h00, 1'b1, SDA_HIGH, 0, 1'b0);
        run_cmd(CMD_READ, 8'hFF, 1'b0, SDA_LOW, 0, 1'b0);
        // stop lands while the read is still running and is dropped
        run_cmd(CMD_READ, 8'h5A, 1'b0, SDA_RAND, -2, 1'b1);
        run_cmd(CMD_STOP, 8'h00, 1'b0, SDA_RAND, 2, 1'b0);
        settle(22);

        hp_plan    = '{1, 0, 2, 1, 3, 5, 4};
        hp_plan[6] = $urandom_range(1, 4);
        foreach (hp_plan[k])
        begin
            set_half_period(10'(hp_plan[k]));
            hpe  = (hp_plan[k] == 0) ? 1 : hp_plan[k];
            mark = ticks_sent;
            while (ticks_sent - mark < TICKS_PER_HP)
            begin
                if ($urandom_range(0, 9) < 8)
                    bus_frame();
                else
                    repeat ($urandom_range(1, 8))
                        send_tick(3'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
            end
            in_gaps = 1'b1;
            settle(20 * hpe + 2);
        end

        // widest half period: the start has to stay in its first phase
        set_half_period(10'd1023);
        send_tick(CMD_START, 8'($urandom), 1'b0, 1'($urandom));
        settle(40);

        repeat (10) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("i2c_byte_master_unit_tb OK");
        else
            $display("i2c_byte_master_unit_tb NOT OK");
        $finish;
    end

endmodule
